FILE: sv/rki_pkg.sv
// rki_pkg: shared constants and the token type for the rank indexer.
// No dependencies; used by all other source files of the project.
`timescale 1ns / 1ps

package rki_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 32;
  localparam int RANK_W    = 6;
  localparam int SLOT_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Token travelling down the chain: a new value looking for its slot.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] key;
    logic [RANK_W-1:0]         below;
    logic [SLOT_W-1:0]         slot;
  } tok_t;

endpackage

FILE: sv/rki_in_if.sv
// rki_in_if: request channel carrying values into the rank indexer.
// Depends on rki_pkg.
`timescale 1ns / 1ps

interface rki_in_if;
  import rki_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

FILE: sv/rki_out_if.sv
// rki_out_if: request channel carrying ranks out of the rank indexer.
// Depends on rki_pkg.
`timescale 1ns / 1ps

interface rki_out_if;
  import rki_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic              last_rank;
  logic              overflow;

  modport source (output valid, rank, last_rank, overflow, input ready);
  modport sink   (input valid, rank, last_rank, overflow, output ready);
endinterface

FILE: sv/rki_cell.sv
// rki_cell: one storage cell of the rank chain; holds a value and its count
// of smaller values, and passes tokens and ranks to its neighbours. Uses rki_pkg.
`timescale 1ns / 1ps

module rki_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rki_pkg::SLOT_W-1:0] idx_i,
  input  rki_pkg::tok_t             tok_i,
  output rki_pkg::tok_t             tok_o,
  input  logic                      shift_i,
  input  logic [rki_pkg::RANK_W-1:0] rank_i,
  output logic [rki_pkg::RANK_W-1:0] rank_o
);
  import rki_pkg::*;

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [RANK_W-1:0]         cnt_q, cnt_d;
  tok_t                      tok_q, tok_d;
  logic                      match;

  assign match = tok_i.valid && (tok_i.slot == idx_i);

  always_comb begin
    tok_d       = tok_i;
    tok_d.valid = tok_i.valid && !match;
    if (tok_i.valid && !match && (val_q < tok_i.key)) begin
      tok_d.below = tok_i.below + RANK_W'(1);
    end

    val_d = match ? tok_i.key : val_q;

    // shifting only happens while no token is in flight
    priority if (shift_i) begin
      cnt_d = rank_i;
    end else if (match) begin
      cnt_d = tok_i.below;
    end else if (tok_i.valid && (tok_i.key < val_q)) begin
      cnt_d = cnt_q + RANK_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
  end

  assign tok_o  = tok_q;
  assign rank_o = cnt_q;

endmodule

FILE: sv/rank_indexer.sv
// rank_indexer: ranks a stream of signed values with a chain of MAX_ITEMS cells.
// Loading takes one request per cycle; after the closing request the chain drains until no
// token is in flight, then the stored ranks leave one per cycle while the sink is ready.
// Input ready stays low from the closing request until the last rank is taken.
// Reset (rst_ni low, asynchronous) empties the chain and returns to loading.
// Depends on rki_pkg, rki_in_if, rki_out_if and rki_cell.
`timescale 1ns / 1ps

module rank_indexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  rki_in_if.sink        in_i,
  rki_out_if.source     out_o
);
  import rki_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] remain_q;
  logic             ovf_q;

  tok_t             tok_w [MAX_ITEMS+1];
  logic [RANK_W-1:0] rank_w [MAX_ITEMS+1];
  logic             in_acc;
  logic             out_acc;
  logic             room;
  logic             busy;
  logic             shift;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign room       = (cnt_q < CNT_W'(MAX_ITEMS));
  assign shift      = out_acc;

  assign tok_w[0] = {in_acc && room, in_i.value, RANK_W'(0), cnt_q[SLOT_W-1:0]};

  assign rank_w[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rki_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SLOT_W'(i)),
      .tok_i   (tok_w[i]),
      .tok_o   (tok_w[i+1]),
      .shift_i (shift),
      .rank_i  (rank_w[i+1]),
      .rank_o  (rank_w[i])
    );
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= MAX_ITEMS; i++) begin
      busy = busy | tok_w[i].valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      remain_q    <= '0;
      ovf_q       <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.last_item) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_q     <= ST_EMIT;
            remain_q    <= cnt_q;
            out_o.valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            remain_q <= remain_q - CNT_W'(1);
            if (remain_q == CNT_W'(1)) begin
              state_q     <= ST_LOAD;
              cnt_q       <= '0;
              ovf_q       <= 1'b0;
              out_o.valid <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // while emitting, cell 0 holds the next rank in load order
  assign out_o.rank      = rank_w[0];
  assign out_o.last_rank = (remain_q == CNT_W'(1));
  assign out_o.overflow  = ovf_q;

endmodule

FILE: sv/rki_checker.sv
// rki_checker: port-level checks on the rank indexer, attached by bind.
// Depends on rki_pkg and the rank_indexer top level.
`timescale 1ns / 1ps

module rki_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rki_pkg::RANK_W-1:0] out_rank_i,
  input logic                       out_last_i,
  input logic                       out_ovf_i
);
  import rki_pkg::*;

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while results pending");

  a_close_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("input taken after closing request");

  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
    else $error("result after final rank");

  a_burst_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && out_ovf_i == $past(out_ovf_i)))
    else $error("burst broken or overflow flag changed");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_rank_i)))
    else $error("stalled rank not held");

endmodule

bind rank_indexer rki_checker u_rki_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rank_i  (out_o.rank),
  .out_last_i  (out_o.last_rank),
  .out_ovf_i   (out_o.overflow)
);

FILE: tb/rank_indexer_test.sv
// rank_indexer_test: self-checking bench for rank_indexer; ranks predicted in the bench
// and compared result by result. Depends on rki_pkg, rki_in_if, rki_out_if, rank_indexer.
`timescale 1ns / 1ps

module rank_indexer_test;
  import rki_pkg::*;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
    logic              overflow;
  } rank_result_t;

  localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  rki_in_if  in_if ();
  rki_out_if out_if ();

  rank_indexer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state: the current sequence as loaded so far
  logic signed [VALUE_W-1:0] held_values [MAX_ITEMS];
  int                        held_count;
  bit                        dropped_seen;
  rank_result_t              expected_ranks [$];

  bit sender_gaps_on;
  bit sink_gaps_on;
  int holdoff_cycles;

  int mismatch_count;
  int sequences_sent;
  int values_accepted;
  int ranks_checked;
  int overflow_runs;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // records a taken value; on close, works out the ranks and queues them in load order
  task automatic record_request(input logic signed [VALUE_W-1:0] value, input logic last_item);
    int below;
    rank_result_t res;
    values_accepted++;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = value;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (last_item) begin
      for (int k = 0; k < held_count; k++) begin
        below = 0;
        for (int j = 0; j < held_count; j++)
          if (held_values[j] < held_values[k]) below++;
        res.rank      = below[RANK_W-1:0];
        res.last_rank = (k == held_count - 1);
        res.overflow  = dropped_seen;
        expected_ranks.push_back(res);
      end
      sequences_sent++;
      if (dropped_seen) overflow_runs++;
      held_count   = 0;
      dropped_seen = 1'b0;
    end
  endtask

  // call on a clock edge; returns on the edge at which the request is taken
  task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic last_item);
    while (sender_gaps_on && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= value;
    in_if.last_item <= last_item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    record_request(value, last_item);
  endtask

  // mostly wide random values, with a share of near-zero values for ties, and the extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int near_zero;
    near_zero = $urandom_range(8);
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2, 3, 4: return near_zero - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sequence(input int length);
    for (int i = 0; i < length; i++) send_value(pick_value(), i == length - 1);
  endtask

  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_ranks.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_value();
    send_value(MOST_NEG, 1'b1);
  endtask

  task automatic test_extremes();
    logic signed [VALUE_W-1:0] vals [8];
    vals = '{MOST_POS, MOST_NEG, 0, -1, 1, MOST_NEG, MOST_POS, 0};
    for (int i = 0; i < 8; i++) send_value(vals[i], i == 7);
  endtask

  task automatic test_equal_values();
    for (int i = 0; i < 4; i++) send_value(-1, i == 3);
  endtask

  task automatic test_descending();
    for (int i = 0; i < 5; i++) send_value(100 - 50 * i, i == 4);
  endtask

  task automatic test_full_capacity();
    send_sequence(MAX_ITEMS);
  endtask

  // closing request lands beyond capacity and is dropped
  task automatic test_overflow();
    send_sequence(MAX_ITEMS + 1 + $urandom_range(5));
  endtask

  // sink stalls long enough that the second and third sequences back up at the input
  task automatic test_receiver_holdoff();
    sender_gaps_on = 1'b0;
    holdoff_cycles = 200;
    for (int s = 0; s < 3; s++) send_sequence(5);
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_drain_between_sequences();
    for (int s = 0; s < 3; s++) begin
      send_sequence(1 + $urandom_range(7));
      pause_until_drained();
    end
  endtask

  task automatic test_random_sequences();
    int sent;
    int length;
    sent = 0;
    while (sent < 40) begin
      // second half runs with no idling on either side
      if (sent >= 20) begin
        sender_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
      end
      length = ($urandom_range(9) == 0) ? 1 + $urandom_range(MAX_ITEMS - 1)
                                        : 1 + $urandom_range(7);
      if (length > 40 - sent && sent > 0) length = 40 - sent;
      send_sequence(length);
      sent += length;
    end
    sender_gaps_on = 1'b1;
    sink_gaps_on   = 1'b1;
  endtask

  // sink side: random idling, plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk_i);
        holdoff_cycles = 0;
      end
      out_if.ready <= !(sink_gaps_on && $urandom_range(99) < 15);
    end
  end

  always @(posedge clk_i) begin
    rank_result_t got;
    rank_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.rank      = out_if.rank;
      got.last_rank = out_if.last_rank;
      got.overflow  = out_if.overflow;
      if (expected_ranks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected rank: got rank=%0d last=%0b ovf=%0b",
                 $time, got.rank, got.last_rank, got.overflow);
      end else begin
        want = expected_ranks.pop_front();
        ranks_checked++;
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: rank mismatch: expected rank=%0d last=%0b ovf=%0b,",
                   $time, want.rank, want.last_rank, want.overflow);
          $display("    got rank=%0d last=%0b ovf=%0b",
                   got.rank, got.last_rank, got.overflow);
        end
      end
    end
  end

  initial begin
    held_count      = 0;
    dropped_seen    = 1'b0;
    sender_gaps_on  = 1'b1;
    sink_gaps_on    = 1'b1;
    holdoff_cycles  = 0;
    mismatch_count  = 0;
    sequences_sent  = 0;
    values_accepted = 0;
    ranks_checked   = 0;
    overflow_runs   = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.last_item <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_value();
    test_extremes();
    test_equal_values();
    test_descending();
    test_full_capacity();
    test_overflow();
    test_receiver_holdoff();
    test_drain_between_sequences();
    test_random_sequences();

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_ITEMS + 10) @(posedge clk_i);

    $display("Covered %0d sequences, %0d values taken, %0d ranks checked.",
             sequences_sent, values_accepted, ranks_checked);
    $display("Overflowing sequences: %0d; mismatches: %0d.", overflow_runs, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rki_pkg.sv
sv/rki_in_if.sv
sv/rki_out_if.sv
sv/rki_cell.sv
sv/rank_indexer.sv
sv/rki_checker.sv
tb/rank_indexer_test.sv
